// ----- hw/rtl/lud_pkg.sv -----
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types, sizes and command codes for the in-place LU factorization block.
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int MaxDim    = 8;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int IdxW      = 3;
    localparam int AddrW     = 6;
    localparam int AccW      = 72;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_OUT,
        ST_EL_INIT,
        ST_EL_AREAD,
        ST_K_ISSUE,
        ST_K_WAIT,
        ST_K_MUL,
        ST_K_ACC,
        ST_PIV_READ,
        ST_FINISH,
        ST_DIV,
        ST_WRITE,
        ST_NEXT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

endpackage

// ----- hw/rtl/lud_ram.sv -----
// ----------------------------------------------------------------------------
// lud_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lud_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lud_div.sv -----
// ----------------------------------------------------------------------------
// lud_div
// Restoring divider: magnitude of a wide numerator by a 32-bit magnitude, one
// quotient bit per cycle, full-width quotient.
// ----------------------------------------------------------------------------
module lud_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lud_pkg::AccW-1:0]     i_num,
    input  logic [lud_pkg::DataWidth-1:0] i_den,
    output logic                         o_done,
    output logic [lud_pkg::AccW-1:0]     o_quot
);

    localparam int CntW = $clog2(lud_pkg::AccW + 1);

    logic [lud_pkg::AccW-1:0]      r_q, n_q;
    logic [lud_pkg::DataWidth:0]   r_rem, n_rem;
    logic [CntW-1:0]               r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [lud_pkg::DataWidth+1:0] w_shift;
    logic [lud_pkg::DataWidth+1:0] w_diff;

    always_comb begin
        w_shift = {r_rem, r_q[lud_pkg::AccW-1]};
        w_diff  = w_shift - {2'b00, i_den};
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CntW'(lud_pkg::AccW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[lud_pkg::DataWidth+1]) begin
                n_rem = w_diff[lud_pkg::DataWidth:0];
                n_q   = {r_q[lud_pkg::AccW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[lud_pkg::DataWidth:0];
                n_q   = {r_q[lud_pkg::AccW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/lu_decomposition_inplace.sv -----
// ----------------------------------------------------------------------------
// lu_decomposition_inplace
// In-place Doolittle LU factorization of a signed Q16.16 matrix, no pivoting.
//
// Input channel (i_valid/o_ready) carries one command per transaction: write
// an element, start factorization, or read an element. A read returns one
// output transaction (o_valid/i_ready) with the element and the singular and
// saturated flags, via the RAM read register and an output register. A start
// runs the factorization with one shared multiply-accumulate unit and one
// bit-serial divider over the 8x8 store: each product term is issued, read,
// multiplied and accumulated in turn, and each lower element waits on the
// divider. The store is a single RAM whose one read port sets the term rate.
// The input is not ready while a command is being processed or while a read
// result waits; a stalled receiver holds the result and the block with it.
// Reset clears the flags, sets the order to 8 and idles the sequencer; the
// store contents are undefined until written. The config channel
// (i_cfg_valid/o_cfg_ready) sets the order n and is always ready.
// ----------------------------------------------------------------------------
module lu_decomposition_inplace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_row,
    input  logic [2:0]  i_col,
    input  logic signed [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_read_data,
    output logic        o_singular,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_size_in_use
);

    localparam int AW = lud_pkg::AccW;
    localparam int DW = lud_pkg::DataWidth;
    localparam int IW = lud_pkg::IdxW;

    lud_pkg::t_state r_state, n_state;

    logic [3:0]          r_size;
    logic                r_sing, n_sing, r_sat, n_sat;
    logic [IW-1:0]       r_r, n_r, r_i, n_i, r_j, n_j, r_k, n_k;
    logic                r_lower, n_lower;
    logic [IW:0]         r_n, n_n;
    logic signed [AW-1:0] r_acc, n_acc;
    logic signed [DW-1:0] r_a, n_a;
    logic signed [2*DW-1:0] r_prod, n_prod;
    logic signed [DW-1:0] r_piv, n_piv;
    logic signed [DW-1:0] r_out, n_out;
    logic                r_oval, n_oval;
    logic signed [DW-1:0] r_res, n_res;

    logic                w_we;
    logic [lud_pkg::AddrW-1:0] w_waddr, w_raddr;
    logic [DW-1:0]       w_wdata, w_rdata;

    logic                w_div_done;
    logic [AW-1:0]       w_quot;
    lud_pkg::t_div_ctl   w_div;
    logic [AW-1:0]       w_num_mag;
    logic [DW-1:0]       w_den_mag;

    logic signed [AW-1:0] w_sar;
    logic signed [AW-1:0] w_q;
    logic signed [DW-1:0] w_clip;
    logic                w_clipped;
    logic                w_acc_neg;
    logic                w_fin_sel;

    lud_ram #(.Width(DW), .Depth(lud_pkg::MaxDim * lud_pkg::MaxDim)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_acc_neg = r_acc[AW-1];
    assign w_num_mag = w_acc_neg ? AW'(-r_acc) : AW'(r_acc);
    assign w_den_mag = r_piv[DW-1] ? DW'(-r_piv) : DW'(r_piv);
    assign w_sar     = r_acc >>> lud_pkg::FracBits;
    assign w_q       = (w_acc_neg != r_piv[DW-1]) ? -$signed(w_quot) : $signed(w_quot);
    assign w_fin_sel = r_lower;

    lud_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div.start),
        .i_num  (w_num_mag),
        .i_den  (w_den_mag),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_comb begin
        logic signed [AW-1:0] v;
        v = w_fin_sel ? w_q : w_sar;
        w_clipped = 1'b0;
        w_clip    = v[DW-1:0];
        if (v > $signed(AW'({1'b0, {(DW-1){1'b1}}}))) begin
            w_clipped = 1'b1;
            w_clip    = {1'b0, {(DW-1){1'b1}}};
        end else if (v < -$signed(AW'({1'b1, {(DW-1){1'b0}}}))) begin
            w_clipped = 1'b1;
            w_clip    = {1'b1, {(DW-1){1'b0}}};
        end
    end

    // element (row,col) being computed: upper -> (r, j), lower -> (j, r)
    always_comb begin
        n_state   = r_state;
        n_sing    = r_sing;
        n_sat     = r_sat;
        n_r       = r_r;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_lower   = r_lower;
        n_n       = r_n;
        n_acc     = r_acc;
        n_a       = r_a;
        n_prod    = r_prod;
        n_piv     = r_piv;
        n_out     = r_out;
        n_oval    = r_oval;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = {i_row, i_col};
        w_wdata   = i_value;
        w_raddr   = {i_row, i_col};
        w_div     = '{start: 1'b0};
        o_ready   = 1'b0;
        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            lud_pkg::ST_IDLE: begin
                o_ready = !r_oval;
                if (i_valid && !r_oval) begin
                    unique case (lud_pkg::t_cmd'(i_command))
                        lud_pkg::CMD_WRITE: w_we = 1'b1;
                        lud_pkg::CMD_READ: begin
                            n_state   = lud_pkg::ST_RD_WAIT;
                        end
                        lud_pkg::CMD_START: begin
                            n_sing  = 1'b0;
                            n_sat   = 1'b0;
                            n_n     = (r_size == 4'd0) ? 4'd1
                                    : (r_size > 4'd8) ? 4'd8 : r_size;
                            n_r     = '0;
                            n_j     = '0;
                            n_lower = 1'b0;
                            n_state = lud_pkg::ST_EL_INIT;
                        end
                        lud_pkg::CMD_NONE: ;
                    endcase
                end
            end
            lud_pkg::ST_RD_WAIT: begin
                n_out   = w_rdata;
                n_state = lud_pkg::ST_RD_OUT;
            end
            lud_pkg::ST_RD_OUT: begin
                n_oval  = 1'b1;
                n_state = lud_pkg::ST_IDLE;
            end
            lud_pkg::ST_EL_INIT: begin
                w_raddr = r_lower ? {r_j, r_r} : {r_r, r_j};
                n_k     = '0;
                n_state = lud_pkg::ST_EL_AREAD;
            end
            lud_pkg::ST_EL_AREAD: begin
                n_acc   = AW'($signed(w_rdata)) <<< lud_pkg::FracBits;
                n_state = (r_r == '0) ? lud_pkg::ST_PIV_READ : lud_pkg::ST_K_ISSUE;
            end
            lud_pkg::ST_K_ISSUE: begin
                w_raddr = r_lower ? {r_j, r_k} : {r_r, r_k};
                n_state = lud_pkg::ST_K_WAIT;
            end
            lud_pkg::ST_K_WAIT: begin
                w_raddr = r_lower ? {r_k, r_r} : {r_k, r_j};
                n_a     = w_rdata;
                n_state = lud_pkg::ST_K_MUL;
            end
            lud_pkg::ST_K_MUL: begin
                n_prod  = r_a * $signed(w_rdata);
                n_state = lud_pkg::ST_K_ACC;
            end
            lud_pkg::ST_K_ACC: begin
                n_acc = r_acc - AW'(r_prod);
                n_k   = r_k + 1'b1;
                n_state = (r_k + 1'b1 == r_r) ? lud_pkg::ST_PIV_READ
                                              : lud_pkg::ST_K_ISSUE;
            end
            lud_pkg::ST_PIV_READ: begin
                w_raddr = {r_r, r_r};
                n_state = lud_pkg::ST_FINISH;
            end
            lud_pkg::ST_FINISH: begin
                n_piv = w_rdata;
                if (!r_lower) begin
                    n_res   = w_clip;
                    n_sat   = r_sat | w_clipped;
                    n_state = lud_pkg::ST_WRITE;
                end else if (w_rdata == '0) begin
                    n_sing  = 1'b1;
                    n_sat   = 1'b1;
                    n_res   = w_acc_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                    n_state = lud_pkg::ST_WRITE;
                end else begin
                    n_state = lud_pkg::ST_DIV;
                end
            end
            lud_pkg::ST_DIV: begin
                w_div.start = (r_i == '0);
                n_i = 3'd1;
                if (w_div_done) begin
                    n_i     = '0;
                    n_res   = w_clip;
                    n_sat   = r_sat | w_clipped;
                    n_state = lud_pkg::ST_WRITE;
                end
            end
            lud_pkg::ST_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_lower ? {r_j, r_r} : {r_r, r_j};
                w_wdata = r_res;
                n_state = lud_pkg::ST_NEXT;
            end
            lud_pkg::ST_NEXT: begin
                n_state = lud_pkg::ST_EL_INIT;
                if ({1'b0, r_j} + 1'b1 < r_n) begin
                    n_j = r_j + 1'b1;
                end else if (!r_lower && ({1'b0, r_r} + 1'b1 < r_n)) begin
                    n_lower = 1'b1;
                    n_j     = r_r + 1'b1;
                end else if (r_lower && ({1'b0, r_r} + 1'b1 < r_n)) begin
                    n_lower = 1'b0;
                    n_r     = r_r + 1'b1;
                    n_j     = r_r + 1'b1;
                end else begin
                    n_state = lud_pkg::ST_IDLE;
                end
            end
            default: n_state = lud_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lud_pkg::ST_IDLE;
            r_size  <= 4'd8;
            r_sing  <= 1'b0;
            r_sat   <= 1'b0;
            r_oval  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_sing  <= n_sing;
            r_sat   <= n_sat;
            r_oval  <= n_oval;
            r_i     <= n_i;
            if (i_cfg_valid) begin
                r_size <= i_cfg_size_in_use;
            end
        end
        r_r       <= n_r;
        r_j       <= n_j;
        r_k       <= n_k;
        r_lower   <= n_lower;
        r_n       <= n_n;
        r_acc     <= n_acc;
        r_a       <= n_a;
        r_prod    <= n_prod;
        r_piv     <= n_piv;
        r_out     <= n_out;
        r_res     <= n_res;
    end

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_oval;
    assign o_read_data = r_out;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

endmodule
